// ===== rtl/egcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types and constants for the extended GCD block: default operand
// width, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package egcd_pkg;

	localparam int unsigned EGCD_WIDTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} egcd_state_t;

	typedef struct packed {
		logic load;      // capture operands, seed coefficients
		logic div_init;  // clear partial remainder, products and bit counter
		logic div_step;  // one restoring division bit
		logic update;    // shift remainders and coefficients by one Euclid step
	} egcd_cmd_t;

	typedef struct packed {
		logic cur_zero;  // current remainder is zero: algorithm finished
		logic cnt_last;  // last quotient bit in progress
	} egcd_status_t;

endpackage

// ===== rtl/egcd_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_dpath
// Remainder and coefficient registers with a bit-serial restoring divider.
// The quotient is folded into both coefficient products one bit at a time.
// ----------------------------------------------------------------------------
module egcd_dpath #(
	parameter int unsigned WIDTH = egcd_pkg::EGCD_WIDTH
) (
	input  logic                    clk,
	input  egcd_pkg::egcd_cmd_t     cmd,
	output egcd_pkg::egcd_status_t  status,
	input  logic [WIDTH-1:0]        operand_a,
	input  logic [WIDTH-1:0]        operand_b,
	output logic [WIDTH-1:0]        divisor,
	output logic signed [WIDTH:0]   coef_a,
	output logic signed [WIDTH:0]   coef_b
);
	import egcd_pkg::*;

	localparam int unsigned CNT_W = $clog2(WIDTH);

	logic [WIDTH-1:0] rem_prev_q;
	logic [WIDTH-1:0] rem_cur_q;
	logic [WIDTH:0]   xa_prev_q;
	logic [WIDTH:0]   xa_cur_q;
	logic [WIDTH:0]   xb_prev_q;
	logic [WIDTH:0]   xb_cur_q;
	logic [WIDTH-1:0] part_q;
	logic [WIDTH-1:0] dvd_q;
	logic [WIDTH:0]   pa_q;
	logic [WIDTH:0]   pb_q;
	logic [CNT_W-1:0] cnt_q;

	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;
	logic             qbit;
	logic [WIDTH-1:0] part_next;
	logic [WIDTH:0]   pa_next;
	logic [WIDTH:0]   pb_next;

	always_comb begin
		shifted   = {part_q, dvd_q[WIDTH-1]};
		diff      = shifted - {1'b0, rem_cur_q};
		// shifted stays below twice the divisor, so the sign bit tells it all
		qbit      = ~diff[WIDTH];
		part_next = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
		// Horner form of q * x, MSB first, wrapping at WIDTH+1 bits
		pa_next   = {pa_q[WIDTH-1:0], 1'b0} + (qbit ? xa_cur_q : '0);
		pb_next   = {pb_q[WIDTH-1:0], 1'b0} + (qbit ? xb_cur_q : '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_prev_q <= operand_a;
			rem_cur_q  <= operand_b;
			xa_prev_q  <= {{WIDTH{1'b0}}, 1'b1};
			xa_cur_q   <= '0;
			xb_prev_q  <= '0;
			xb_cur_q   <= {{WIDTH{1'b0}}, 1'b1};
		end else if (cmd.update) begin
			rem_prev_q <= rem_cur_q;
			rem_cur_q  <= part_q;
			xa_prev_q  <= xa_cur_q;
			xa_cur_q   <= xa_prev_q - pa_q;
			xb_prev_q  <= xb_cur_q;
			xb_cur_q   <= xb_prev_q - pb_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			part_q <= '0;
			dvd_q  <= rem_prev_q;
			pa_q   <= '0;
			pb_q   <= '0;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			part_q <= part_next;
			dvd_q  <= {dvd_q[WIDTH-2:0], qbit};
			pa_q   <= pa_next;
			pb_q   <= pb_next;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	assign status.cur_zero = (rem_cur_q == '0);
	assign status.cnt_last = (cnt_q == CNT_W'(WIDTH - 1));

	assign divisor = rem_prev_q;
	assign coef_a  = xa_prev_q;
	assign coef_b  = xb_prev_q;

endmodule

// ===== rtl/egcd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_ctrl
// Sequencer for the extended GCD: check, divide bit by bit, update, repeat
// until the remainder is zero, then strobe the result.
// ----------------------------------------------------------------------------
module egcd_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  egcd_pkg::egcd_status_t  status,
	output egcd_pkg::egcd_cmd_t     cmd,
	output logic                    busy,
	output logic                    done
);
	import egcd_pkg::*;

	egcd_state_t state_q;
	egcd_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				state_next = status.cur_zero ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (status.cnt_last) state_next = ST_UPDATE;
			end
			ST_UPDATE: state_next = ST_CHECK;
			ST_DONE:   state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CHECK:  cmd.div_init = ~status.cur_zero;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_UPDATE: cmd.update   = 1'b1;
			ST_DONE:   done         = 1'b1;
			default:   busy         = 1'b1;
		endcase
	end

endmodule

// ===== rtl/extended_gcd_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_top
// Extended Euclidean algorithm: gcd of two unsigned operands plus the signed
// Bezout coefficients coef_a, coef_b with a*coef_a + b*coef_b = divisor.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   operand_a and operand_b are sampled there. busy stays high until the
//   result has been delivered.
//   The result shows on divisor, coef_a and coef_b, marked by done for exactly
//   one cycle. The receiver cannot stall; it must take the result then.
// Sequence:
//   After accept, the block runs Euclid steps (remainder divisions) until the
//   remainder is zero. Each step is one zero check, the bit-serial restoring
//   divider producing WIDTH quotient bits, and one update. One transaction is
//   in flight at a time, and the next one may be taken the cycle after done.
// Reset:
//   arst_n low drops any transaction in progress and returns to idle.
// ----------------------------------------------------------------------------
module extended_gcd_top #(
	parameter int unsigned WIDTH = egcd_pkg::EGCD_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [WIDTH-1:0]      operand_a,
	input  logic [WIDTH-1:0]      operand_b,
	output logic                  done,
	output logic [WIDTH-1:0]      divisor,
	output logic signed [WIDTH:0] coef_a,
	output logic signed [WIDTH:0] coef_b
);
	import egcd_pkg::*;

	egcd_cmd_t    cmd;
	egcd_status_t status;

	egcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	egcd_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk       (clk),
		.cmd       (cmd),
		.status    (status),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.divisor   (divisor),
		.coef_a    (coef_a),
		.coef_b    (coef_b)
	);

endmodule

// ===== rtl/egcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level checks on the extended GCD block, bound to the top level.
// ----------------------------------------------------------------------------
module egcd_checker #(
	parameter int unsigned WIDTH = egcd_pkg::EGCD_WIDTH
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [WIDTH-1:0]      divisor,
	input logic signed [WIDTH:0] coef_a,
	input logic signed [WIDTH:0] coef_b
);
	import egcd_pkg::*;

	// an accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// a result only appears while a transaction is open, and closes it
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy && !done)
		else $error("done outside a transaction or not followed by idle");

	// busy drops only right after the result strobe
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("transaction ended without a result");

	// gcd zero only for two zero operands, whose coefficients are 1 and 0
	a_zero_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		done && divisor == '0 |-> coef_a == (WIDTH + 1)'(1) && coef_b == '0)
		else $error("wrong coefficients for zero gcd");

endmodule

bind extended_gcd_top egcd_checker #(
	.WIDTH (WIDTH)
) u_egcd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.divisor (divisor),
	.coef_a  (coef_a),
	.coef_b  (coef_b)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for extended_gcd_top. Drives operand pairs through the
// start/busy handshake and checks the gcd and both Bezout coefficients of
// every done strobe against an in-bench Euclid predictor. Directed corner
// cases come first, then random pairs under several sender idle rates.
// ----------------------------------------------------------------------------
module tb;

	import egcd_pkg::*;

	localparam int W = EGCD_WIDTH;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam logic [W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [W-1:0]      divisor;
		logic signed [W:0] coef_a;
		logic signed [W:0] coef_b;
	} bezout_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [W-1:0] operand_a = '0;
	logic [W-1:0] operand_b = '0;
	logic busy;
	logic done;
	logic [W-1:0] divisor;
	logic signed [W:0] coef_a;
	logic signed [W:0] coef_b;

	bezout_t pending_bezout[$];
	bezout_t want;
	int error_count = 0;
	int idle_pct = 0;
	longint cycle_count = 0;

	extended_gcd_top #(.WIDTH(W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.done(done),
		.divisor(divisor),
		.coef_a(coef_a),
		.coef_b(coef_b)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// Iterative extended Euclid; coefficients wrap at 64 bits and are exact
	// once cut to W+1 bits.
	function automatic bezout_t predict_bezout(logic [W-1:0] a, logic [W-1:0] b);
		logic [63:0] r_prev, r_cur, quo, rem, tmp;
		logic [63:0] xa_prev, xa_cur, xb_prev, xb_cur;
		bezout_t res;
		r_prev = 64'(a);
		r_cur = 64'(b);
		xa_prev = 64'd1;
		xa_cur = 64'd0;
		xb_prev = 64'd0;
		xb_cur = 64'd1;
		while (r_cur != 64'd0) begin
			quo = r_prev / r_cur;
			rem = r_prev % r_cur;
			r_prev = r_cur;
			r_cur = rem;
			tmp = xa_prev - quo * xa_cur;
			xa_prev = xa_cur;
			xa_cur = tmp;
			tmp = xb_prev - quo * xb_cur;
			xb_prev = xb_cur;
			xb_cur = tmp;
		end
		res.divisor = r_prev[W-1:0];
		res.coef_a = xa_prev[W:0];
		res.coef_b = xb_prev[W:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
		$display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_bezout.size() == 0) begin
				report_mismatch("unexpected result divisor", 0, longint'(divisor));
			end else begin
				want = pending_bezout.pop_front();
				if (divisor !== want.divisor)
					report_mismatch("divisor", longint'(want.divisor), longint'(divisor));
				if (coef_a !== want.coef_a)
					report_mismatch("coef_a", longint'(want.coef_a), longint'(coef_a));
				if (coef_b !== want.coef_b)
					report_mismatch("coef_b", longint'(want.coef_b), longint'(coef_b));
			end
		end
	end

	// Hold start high across back-to-back transactions; drop it only to idle.
	task automatic send_operands(input logic [W-1:0] a, input logic [W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_bezout.insert(pending_bezout.size(), predict_bezout(a, b));
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_bezout.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [W-1:0] rand_word();
		logic [W-1:0] v;
		int unsigned bits;
		v = W'({$urandom, $urandom});
		case ($urandom_range(9))
			0, 1, 2, 3, 4: ;
			5: v = W'($urandom_range(255));
			6: begin
				bits = $urandom_range(W, 1);
				v = v & (ALL_ONES >> (W - bits));
			end
			7: v = ($urandom_range(1) != 0) ? ALL_ONES : '0;
			default: v = v | (W'(1) << (W - 1));
		endcase
		return v;
	endfunction

	task automatic test_zero_operands();
		send_operands('0, '0);
		send_operands(W'(12345), '0);
		send_operands('0, W'(777));
		send_operands(ALL_ONES, '0);
		send_operands('0, ALL_ONES);
	endtask

	task automatic test_extremes();
		send_operands(ALL_ONES, ALL_ONES);
		send_operands(ALL_ONES, W'(1));
		send_operands(W'(1), ALL_ONES);
		send_operands(ALL_ONES, ALL_ONES - 1);
		send_operands(W'(1), W'(1));
		send_operands(W'(1) << (W - 1), W'(1) << (W - 2));
		send_operands(ALL_ONES, W'(1) << (W - 1));
	endtask

	// Consecutive Fibonacci numbers take the most division steps.
	task automatic test_deep_recursion();
		send_operands(W'(64'd2971215073), W'(64'd1836311903));
		send_operands(W'(64'd1836311903), W'(64'd2971215073));
		send_operands(W'(89), W'(55));
	endtask

	task automatic test_common_factor();
		send_operands(W'(240), W'(46));
		send_operands(W'(46), W'(240));
		send_operands(W'(64'd3000000000), W'(64'd1500000000));
	endtask

	task automatic test_random(input int n_items, input int pct);
		logic [W-1:0] a, b, g;
		idle_pct = pct;
		repeat (n_items) begin
			a = rand_word();
			b = rand_word();
			case ($urandom_range(7))
				4: begin
					g = W'($urandom_range(65535, 1));
					a = g * W'($urandom_range(65535));
					b = g * W'($urandom_range(65535));
				end
				5: if ($urandom_range(1) != 0) a = '0; else b = '0;
				6: a = b * W'($urandom_range(7));
				7: a = b + W'($urandom_range(3));
				default: ;
			endcase
			send_operands(a, b);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_operands();
		test_extremes();
		test_deep_recursion();
		test_common_factor();
		wait_for_results();
		test_random(130, 0);
		test_random(130, 48);
		wait_for_results();
		test_random(130, 9);
		wait_for_results();
		repeat (W + 4) @(posedge clk);
		if (pending_bezout.size() != 0)
			report_mismatch("results still outstanding", 0, pending_bezout.size());
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/egcd_pkg.sv
rtl/egcd_dpath.sv
rtl/egcd_ctrl.sv
rtl/extended_gcd_top.sv
rtl/egcd_checker.sv
bench/tb.sv
